>>> rtl/csa_pkg.sv
// ----------------------------------------------------------------------------
// csa_pkg
// Types and constants shared by the controller and the datapath of the
// cosine similarity accumulator.
// ----------------------------------------------------------------------------
package csa_pkg;

  localparam int COUNT_BITS = 16;
  localparam int ACC_BITS   = 38;
  localparam int HALF_BITS  = ACC_BITS / 2;
  localparam int PROD_BITS  = 2 * ACC_BITS;
  localparam int ROOT_BITS  = ACC_BITS;
  localparam int FRAC_BITS  = 16;
  localparam int NUM_BITS   = ACC_BITS + FRAC_BITS;
  localparam int SIM_BITS   = FRAC_BITS + 1;
  localparam int STEP_BITS  = 6;

  localparam logic [ACC_BITS-1:0]  ACC_MAX     = {ACC_BITS{1'b1}};
  localparam logic [SIM_BITS-1:0]  ONE_Q16     = SIM_BITS'(1) << FRAC_BITS;
  localparam logic [STEP_BITS-1:0] MUL_PARTS   = STEP_BITS'(4);
  localparam logic [STEP_BITS-1:0] MUL_DONE    = STEP_BITS'(5);
  localparam logic [STEP_BITS-1:0] SQRT_DONE   = STEP_BITS'(ROOT_BITS);
  localparam logic [STEP_BITS-1:0] DIV_DONE    = STEP_BITS'(NUM_BITS);

  typedef struct packed {
    logic capture;
    logic accumulate;
    logic mul_init;
    logic mul_run;
    logic sqrt_init;
    logic sqrt_run;
    logic div_init;
    logic div_run;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic last_pair;
    logic mul_done;
    logic sqrt_done;
    logic div_done;
    logic out_full;
  } stat_t;

endpackage

>>> rtl/cosine_similarity_accumulator.sv
// ----------------------------------------------------------------------------
// cosine_similarity_accumulator
// A pair of term counts is transferred per item; the pair marked last closes
// the vectors and produces one cosine similarity in unsigned Q1.16. A pair
// that is not last is transferred and then accumulated with saturation before
// the next pair can be transferred. The last pair further occupies the block
// for the 76-bit norm product on one shared 19x19 multiplier, the square root
// at two radicand bits per cycle, the bit-serial 54-bit division and the hand-off
// of the result to the output register, which waits while that register still
// holds a stalled result. The next vector may start while that result waits to be
// transferred. A zero norm gives similarity 0 with undefined set.
// ----------------------------------------------------------------------------
module cosine_similarity_accumulator (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [csa_pkg::COUNT_BITS-1:0] count_a,
  input  logic [csa_pkg::COUNT_BITS-1:0] count_b,
  input  logic                           last,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [csa_pkg::SIM_BITS-1:0]   similarity,
  output logic                           undefined
);

  csa_pkg::cmd_t  cmd;
  csa_pkg::stat_t stat;

  csa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  csa_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .count_a    (count_a),
    .count_b    (count_b),
    .last       (last),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .similarity (similarity),
    .undefined  (undefined)
  );

endmodule

>>> rtl/csa_ctrl.sv
// ----------------------------------------------------------------------------
// csa_ctrl
// Sequencer that steps the datapath through accumulation, the norm product,
// the square root, the division and the hand-off to the output register.
// ----------------------------------------------------------------------------
module csa_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  csa_pkg::stat_t stat,
  output csa_pkg::cmd_t  cmd
);

  typedef enum logic [2:0] {
    IDLE,
    ACC,
    MUL,
    SQRT,
    DIV,
    FINISH
  } state_t;

  state_t state;
  state_t state_next;

  assign in_stall = (state != IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ACC;
        end
      end
      ACC: begin
        cmd.accumulate = 1'b1;
        if (stat.last_pair) begin
          cmd.mul_init = 1'b1;
          state_next   = MUL;
        end else begin
          state_next = IDLE;
        end
      end
      MUL: begin
        if (stat.mul_done) begin
          cmd.sqrt_init = 1'b1;
          state_next    = SQRT;
        end else begin
          cmd.mul_run = 1'b1;
        end
      end
      SQRT: begin
        if (stat.sqrt_done) begin
          cmd.div_init = 1'b1;
          state_next   = DIV;
        end else begin
          cmd.sqrt_run = 1'b1;
        end
      end
      DIV: begin
        if (stat.div_done) begin
          state_next = FINISH;
        end else begin
          cmd.div_run = 1'b1;
        end
      end
      FINISH: begin
        if (!stat.out_full) begin
          cmd.load_out = 1'b1;
          state_next   = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> rtl/csa_dp.sv
// ----------------------------------------------------------------------------
// csa_dp
// Datapath: saturating sums, a shared 19x19 multiplier for the norm product,
// a two-bit-per-step square root, a bit-serial divider and the output register.
// ----------------------------------------------------------------------------
module csa_dp (
  input  logic                               clk,
  input  logic                               rst,
  input  csa_pkg::cmd_t                      cmd,
  output csa_pkg::stat_t                     stat,
  input  logic [csa_pkg::COUNT_BITS-1:0]     count_a,
  input  logic [csa_pkg::COUNT_BITS-1:0]     count_b,
  input  logic                               last,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [csa_pkg::SIM_BITS-1:0]       similarity,
  output logic                               undefined
);

  localparam int PP_BITS  = 2 * csa_pkg::COUNT_BITS;
  localparam int HB       = csa_pkg::HALF_BITS;
  localparam int AB       = csa_pkg::ACC_BITS;
  localparam int PB       = csa_pkg::PROD_BITS;
  localparam int RB       = csa_pkg::ROOT_BITS;
  localparam int NB       = csa_pkg::NUM_BITS;
  localparam int REM_BITS = RB + 2;

  function automatic logic [AB-1:0] sat_add(input logic [AB-1:0] acc,
                                            input logic [PP_BITS-1:0] inc);
    logic [AB:0] sum;
    sum = {1'b0, acc} + (AB + 1)'(inc);
    if (sum >= {1'b0, csa_pkg::ACC_MAX}) begin
      return csa_pkg::ACC_MAX;
    end
    return sum[AB-1:0];
  endfunction

  logic [PP_BITS-1:0]           prod_ab;
  logic [PP_BITS-1:0]           prod_aa;
  logic [PP_BITS-1:0]           prod_bb;
  logic                         last_flag;
  logic [AB-1:0]                dot_sum;
  logic [AB-1:0]                norm_a_sum;
  logic [AB-1:0]                norm_b_sum;
  logic [csa_pkg::STEP_BITS-1:0] step;
  logic [PB-1:0]                pp;
  logic                         pp_vld;
  logic [PB-1:0]                prod;
  logic [PB-1:0]                rad;
  logic [REM_BITS-1:0]          sq_rem;
  logic [RB-1:0]                root;
  logic [RB-1:0]                div_rem;
  logic [NB-1:0]                num;

  logic [HB-1:0]                op_a;
  logic [HB-1:0]                op_b;
  logic [2*HB-1:0]              mul;
  logic [PB-1:0]                mul_shifted;
  logic [REM_BITS+1:0]          sq_shift;
  logic [REM_BITS+1:0]          sq_trial;
  logic                         sq_ge;
  logic [RB:0]                  dv_shift;
  logic                         dv_ge;
  logic                         zero_norm;
  logic [csa_pkg::SIM_BITS-1:0] quot_clamped;

  always_comb begin
    case (step[1:0])
      2'd0: begin
        op_a = norm_a_sum[HB-1:0];
        op_b = norm_b_sum[HB-1:0];
      end
      2'd1: begin
        op_a = norm_a_sum[HB-1:0];
        op_b = norm_b_sum[AB-1:HB];
      end
      2'd2: begin
        op_a = norm_a_sum[AB-1:HB];
        op_b = norm_b_sum[HB-1:0];
      end
      default: begin
        op_a = norm_a_sum[AB-1:HB];
        op_b = norm_b_sum[AB-1:HB];
      end
    endcase
  end

  assign mul = op_a * op_b;

  always_comb begin
    case (step[1:0])
      2'd0:    mul_shifted = PB'(mul);
      2'd3:    mul_shifted = PB'(mul) << (2 * HB);
      default: mul_shifted = PB'(mul) << HB;
    endcase
  end

  assign sq_shift = {sq_rem, rad[PB-1:PB-2]};
  assign sq_trial = (REM_BITS + 2)'({root, 2'b01});
  assign sq_ge    = (sq_shift >= sq_trial);

  assign dv_shift = {div_rem, num[NB-1]};
  assign dv_ge    = (dv_shift >= {1'b0, root});

  assign zero_norm    = (norm_a_sum == '0) || (norm_b_sum == '0);
  assign quot_clamped = (num > NB'(csa_pkg::ONE_Q16)) ? csa_pkg::ONE_Q16
                                                       : num[csa_pkg::SIM_BITS-1:0];

  assign stat.last_pair = last_flag;
  assign stat.mul_done  = (step == csa_pkg::MUL_DONE);
  assign stat.sqrt_done = (step == csa_pkg::SQRT_DONE);
  assign stat.div_done  = (step == csa_pkg::DIV_DONE);
  assign stat.out_full  = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      prod_ab   <= count_a * count_b;
      prod_aa   <= count_a * count_a;
      prod_bb   <= count_b * count_b;
      last_flag <= last;
    end

    if (cmd.mul_init || cmd.sqrt_init || cmd.div_init) begin
      step <= '0;
    end else if (cmd.mul_run || cmd.sqrt_run || cmd.div_run) begin
      step <= step + 1'b1;
    end

    if (cmd.mul_init) begin
      prod   <= '0;
      pp_vld <= 1'b0;
    end else if (cmd.mul_run) begin
      pp     <= mul_shifted;
      pp_vld <= (step < csa_pkg::MUL_PARTS);
      if (pp_vld) begin
        prod <= prod + pp;
      end
    end

    if (cmd.sqrt_init) begin
      rad    <= prod;
      sq_rem <= '0;
      root   <= '0;
    end else if (cmd.sqrt_run) begin
      rad    <= rad << 2;
      sq_rem <= sq_ge ? REM_BITS'(sq_shift - sq_trial) : REM_BITS'(sq_shift);
      root   <= {root[RB-2:0], sq_ge};
    end

    if (cmd.div_init) begin
      num     <= {dot_sum, csa_pkg::FRAC_BITS'(0)};
      div_rem <= '0;
    end else if (cmd.div_run) begin
      num     <= {num[NB-2:0], dv_ge};
      div_rem <= dv_ge ? RB'(dv_shift - {1'b0, root}) : dv_shift[RB-1:0];
    end

    if (cmd.load_out) begin
      similarity <= zero_norm ? '0 : quot_clamped;
      undefined  <= zero_norm;
    end

    if (rst) begin
      dot_sum    <= '0;
      norm_a_sum <= '0;
      norm_b_sum <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.load_out) begin
        dot_sum    <= '0;
        norm_a_sum <= '0;
        norm_b_sum <= '0;
      end else if (cmd.accumulate) begin
        dot_sum    <= sat_add(dot_sum, prod_ab);
        norm_a_sum <= sat_add(norm_a_sum, prod_aa);
        norm_b_sum <= sat_add(norm_b_sum, prod_bb);
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> !(out_valid && out_stall))
    else $error("A new result was loaded over one that was not yet transferred.");

  a_acc_after_capture: assert property (@(posedge clk) disable iff (rst)
    cmd.accumulate |-> $past(cmd.capture))
    else $error("Accumulation without a captured pair.");

  a_undefined_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && undefined) |-> (similarity == '0))
    else $error("An undefined result carries a nonzero similarity.");

  a_sim_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (similarity <= csa_pkg::ONE_Q16))
    else $error("Similarity exceeds 1.0.");

endmodule
